@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sncr_pkg.sv @@
// Types and constants for the integer null-constant rewriter.
`timescale 1ns / 1ps
`default_nettype none

package sncr_pkg;

    localparam int TYPE_TABLE_DEPTH  = 16;
    localparam int MAX_LITERAL_WORDS = 4;

    localparam int TT_IDX_W = (TYPE_TABLE_DEPTH > 1) ? $clog2(TYPE_TABLE_DEPTH) : 1;
    localparam int TT_CNT_W = $clog2(TYPE_TABLE_DEPTH + 1);
    localparam int LIT_W    = $clog2(MAX_LITERAL_WORDS + 1);
    localparam int EMIT_W   = $clog2(MAX_LITERAL_WORDS + 2);

    localparam logic [15:0] OP_TYPE_INT      = 16'd21;
    localparam logic [15:0] OP_CONSTANT      = 16'd43;
    localparam logic [15:0] OP_CONSTANT_NULL = 16'd46;
    localparam logic [2:0]  HEADER_WORDS     = 3'd5;

    typedef enum logic [1:0] {
        KIND_OTHER        = 2'd0,
        KIND_INT_TYPE     = 2'd1,
        KIND_NULL_HELD    = 2'd2,
        KIND_NULL_REWRITE = 2'd3
    } t_kind;

endpackage

`default_nettype wire

@@ rtl/spirv_int_null_constant_rewriter.sv @@
// Top level of the integer null-constant rewriter for streamed SPIR-V modules.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one module word per beat,
//   header first, with i_in_last on the final word. Output channel
//   (o_out_valid / i_out_ready) carries the rewritten words, with o_out_last
//   on the final one and the sticky o_malformed / o_table_full flags.
//   A result is registered and appears in the cycle after its beat is taken.
//   One word per cycle, receiver permitting, for words that map one to one. A word
//   that expands into k results holds the output register until all k have
//   drained; input beats are held off until then, and the next beat is taken in
//   the cycle the last result drains. The first word of a null constant produces
//   nothing and is held until its type-id word arrives. The rate is set by the
//   single output register, which moves one result beat per cycle when not
//   stalled. Type lookup is a 16-entry parallel compare done in the same cycle.
//   Reset (synchronous, active low) empties the output register, clears the type
//   table count, header count and flags. That state (not the output register)
//   returns to its reset values after the beat carrying i_in_last is taken. When
//   the receiver stalls, the output register holds its beat and input beats stop
//   being taken once the register cannot drain this cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spirv_int_null_constant_rewriter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_in_word,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_word,
    output logic             o_out_last,
    output logic             o_malformed,
    output logic             o_table_full
);

    localparam int DEPTH  = sncr_pkg::TYPE_TABLE_DEPTH;
    localparam int IDX_W  = sncr_pkg::TT_IDX_W;
    localparam int CNT_W  = sncr_pkg::TT_CNT_W;
    localparam int LIT_W  = sncr_pkg::LIT_W;
    localparam int EMIT_W = sncr_pkg::EMIT_W;

    // Stream tracking state.
    logic [2:0]          r_header_count, n_header_count;
    logic [15:0]         r_words_left,   n_words_left;
    sncr_pkg::t_kind     r_kind,         n_kind;
    logic [1:0]          r_word_index,   n_word_index;   // saturates at 3
    logic [31:0]         r_held_header,  n_held_header;
    logic [31:0]         r_pending_id,   n_pending_id;
    logic [LIT_W-1:0]    r_pending_lit,  n_pending_lit;
    logic [CNT_W-1:0]    r_type_count,   n_type_count;
    logic                r_pass,         n_pass;
    logic                r_overflow,     n_overflow;

    // Integer type table: ids and literal word counts.
    logic [31:0]         r_type_ids [DEPTH];
    logic [LIT_W-1:0]    r_type_lits[DEPTH];

    // Output register: remaining result count, next two words, flags.
    logic [EMIT_W-1:0]   r_out_cnt;
    logic [31:0]         r_out_w0;
    logic [31:0]         r_out_w1;
    logic                r_out_last;
    logic                r_out_malf;
    logic                r_out_full;

    logic                in_acc;
    logic                out_pop;

    // Table lookup.
    logic [31:0]         key;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [LIT_W-1:0]    hit_lit;

    // Table write.
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_widx;
    logic [31:0]         tbl_wid;
    logic [LIT_W-1:0]    tbl_wlit;

    // Results of this beat.
    logic [EMIT_W-1:0]   em_n;
    logic [31:0]         em_w0;
    logic [31:0]         em_w1;
    logic                em_malf;
    logic                em_full;

    logic [15:0]         wc;
    logic [15:0]         op;
    logic [32:0]         width_sum;
    logic [27:0]         width_words;
    logic [LIT_W-1:0]    new_lit;
    logic                truncated;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_out_valid = (r_out_cnt != '0);
    assign o_in_ready  = (r_out_cnt == '0) || (out_pop && (r_out_cnt == EMIT_W'(1)));
    assign o_out_word   = r_out_w0;
    assign o_out_last   = r_out_last && (r_out_cnt == EMIT_W'(1));
    assign o_malformed  = r_out_malf;
    assign o_table_full = r_out_full;

    assign wc = i_in_word[31:16];
    assign op = i_in_word[15:0];

    // Literal word count of an integer width, saturated.
    assign width_sum   = {1'b0, i_in_word} + 33'd31;
    assign width_words = width_sum[32:5];
    assign new_lit     = (width_words > 28'(sncr_pkg::MAX_LITERAL_WORDS))
                         ? LIT_W'(sncr_pkg::MAX_LITERAL_WORDS) : width_words[LIT_W-1:0];

    // Look up the pending id while recording a type, else the incoming word.
    // Recorded ids are unique, so at most one valid entry matches.
    assign key = (r_kind == sncr_pkg::KIND_INT_TYPE) ? r_pending_id : i_in_word;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        hit_lit = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ((CNT_W'(i) < r_type_count) && (r_type_ids[i] == key)) begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
                hit_lit = hit_lit | r_type_lits[i];
            end
        end
    end

    assign truncated = i_in_last && (r_words_left != 16'd1);

    // Next state and the results of one accepted beat.
    always_comb begin
        n_header_count = r_header_count;
        n_words_left   = r_words_left;
        n_kind         = r_kind;
        n_word_index   = r_word_index;
        n_held_header  = r_held_header;
        n_pending_id   = r_pending_id;
        n_pending_lit  = r_pending_lit;
        n_type_count   = r_type_count;
        n_pass         = r_pass;
        n_overflow     = r_overflow;
        tbl_we         = 1'b0;
        tbl_widx       = hit_idx;
        tbl_wid        = r_pending_id;
        tbl_wlit       = new_lit;
        em_n           = EMIT_W'(1);
        em_w0          = i_in_word;
        em_w1          = '0;

        priority if (r_pass) begin
            // Pass-through: the word goes out as is.
        end else if (r_header_count < sncr_pkg::HEADER_WORDS) begin
            n_header_count = r_header_count + 3'd1;
        end else if (r_words_left == '0) begin
            // Instruction start.
            if ((wc == '0) || (i_in_last && (wc > 16'd1))) begin
                n_pass = 1'b1;
            end else begin
                n_words_left = wc - 16'd1;
                n_word_index = 2'd1;
                if ((op == sncr_pkg::OP_CONSTANT_NULL) && (wc == 16'd3)) begin
                    n_kind        = sncr_pkg::KIND_NULL_HELD;
                    n_held_header = i_in_word;
                    em_n          = '0;
                end else if ((op == sncr_pkg::OP_TYPE_INT) && (wc == 16'd4)) begin
                    n_kind = sncr_pkg::KIND_INT_TYPE;
                end else begin
                    n_kind = sncr_pkg::KIND_OTHER;
                end
            end
        end else begin
            n_words_left = r_words_left - 16'd1;
            n_word_index = (r_word_index == 2'd3) ? 2'd3 : r_word_index + 2'd1;
            unique case (r_kind)
                sncr_pkg::KIND_INT_TYPE: begin
                    if (r_word_index == 2'd1) begin
                        n_pending_id = i_in_word;
                    end else if (r_word_index == 2'd2) begin
                        // Record the type: update a known id, append a new one, else flag overflow.
                        if (hit) begin
                            tbl_we = 1'b1;
                        end else if (r_type_count < CNT_W'(DEPTH)) begin
                            tbl_we       = 1'b1;
                            tbl_widx     = r_type_count[IDX_W-1:0];
                            n_type_count = r_type_count + CNT_W'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end
                end
                sncr_pkg::KIND_NULL_HELD: begin
                    em_n  = EMIT_W'(2);
                    em_w1 = i_in_word;
                    if (!truncated && hit) begin
                        n_pending_lit = hit_lit;
                        em_w0  = {16'(32'd3 + 32'(hit_lit)), sncr_pkg::OP_CONSTANT};
                        n_kind = sncr_pkg::KIND_NULL_REWRITE;
                    end else begin
                        em_w0  = r_held_header;
                        n_kind = sncr_pkg::KIND_OTHER;
                    end
                end
                sncr_pkg::KIND_NULL_REWRITE: begin
                    // Result id, then the zero literal words.
                    em_n = EMIT_W'(1) + EMIT_W'(r_pending_lit);
                end
                sncr_pkg::KIND_OTHER: begin
                end
                default: begin
                end
            endcase
            if (truncated) begin
                n_pass = 1'b1;
            end
            if (r_words_left == 16'd1) begin
                n_kind = sncr_pkg::KIND_OTHER;
            end
        end

        em_malf = n_pass;
        em_full = n_overflow;

        // End of module: drop all stream state.
        if (i_in_last) begin
            n_header_count = '0;
            n_words_left   = '0;
            n_kind         = sncr_pkg::KIND_OTHER;
            n_word_index   = '0;
            n_held_header  = '0;
            n_pending_id   = '0;
            n_pending_lit  = '0;
            n_type_count   = '0;
            n_pass         = 1'b0;
            n_overflow     = 1'b0;
        end
    end

    // Stream state registers; advance only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count <= '0;
            r_words_left   <= '0;
            r_kind         <= sncr_pkg::KIND_OTHER;
            r_word_index   <= '0;
            r_held_header  <= '0;
            r_pending_id   <= '0;
            r_pending_lit  <= '0;
            r_type_count   <= '0;
            r_pass         <= 1'b0;
            r_overflow     <= 1'b0;
        end else if (in_acc) begin
            r_header_count <= n_header_count;
            r_words_left   <= n_words_left;
            r_kind         <= n_kind;
            r_word_index   <= n_word_index;
            r_held_header  <= n_held_header;
            r_pending_id   <= n_pending_id;
            r_pending_lit  <= n_pending_lit;
            r_type_count   <= n_type_count;
            r_pass         <= n_pass;
            r_overflow     <= n_overflow;
        end
    end

    // Type table: one write per beat.
    always_ff @(posedge i_clk) begin
        if (in_acc && tbl_we) begin
            r_type_ids[tbl_widx]  <= tbl_wid;
            r_type_lits[tbl_widx] <= tbl_wlit;
        end
    end

    // Output register: load a beat's results, else shift one out per pop.
    // Words after the two loaded ones shift in as zero literals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (in_acc) begin
            r_out_cnt <= em_n;
        end else if (out_pop) begin
            r_out_cnt <= r_out_cnt - EMIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_w0   <= em_w0;
            r_out_w1   <= em_w1;
            r_out_last <= i_in_last;
            r_out_malf <= em_malf;
            r_out_full <= em_full;
        end else if (out_pop) begin
            r_out_w0 <= r_out_w1;
            r_out_w1 <= '0;
        end
    end

    `ASSERT_CLK(a_no_accept_while_busy, i_clk, i_rst_n, (r_out_cnt > EMIT_W'(1)) |-> !o_in_ready, "input taken while several results wait")
    `ASSERT_CLK(a_last_clears_state, i_clk, i_rst_n, (in_acc && i_in_last) |=> (r_type_count == '0 && r_header_count == '0 && !r_pass), "stream state not cleared after last beat")
    `ASSERT_CLK(a_rewrite_one_word_left, i_clk, i_rst_n, (r_kind == sncr_pkg::KIND_NULL_REWRITE) |-> (r_words_left == 16'd1), "rewrite pending with wrong word count")
    `ASSERT_ALWAYS(a_table_count_bound, i_clk, !i_rst_n || (r_type_count <= CNT_W'(DEPTH)), "type table count beyond depth")

endmodule

`default_nettype wire

@@ tb/sv/spirv_int_null_constant_rewriter_test.sv @@
// Self-checking testbench for the SPIR-V integer null-constant rewriter.
`timescale 1ns / 1ps

module spirv_int_null_constant_rewriter_test;

    // Generous run limit: about 200 words, each at most five beats, each
    // beat behind a long receiver stall, taken several times over.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_WORDS  = 50;
    localparam int TYPE_ID_POOL  = 12;

    // One beat of the output channel, as predicted.
    typedef struct {
        logic [31:0] word;
        logic        last;
        logic        malformed;
        logic        table_full;
    } t_out_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_in_word   = '0;
    logic        i_in_last   = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_out_word;
    logic        o_out_last;
    logic        o_malformed;
    logic        o_table_full;

    spirv_int_null_constant_rewriter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word),
        .o_out_last   (o_out_last),
        .o_malformed  (o_malformed),
        .o_table_full (o_table_full)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Rewrite predictor state: mirrors what the block tracks per module.
    // ------------------------------------------------------------------
    logic [2:0]                 hdr_seen;
    logic [15:0]                words_left;
    sncr_pkg::t_kind            kind;
    logic [15:0]                word_idx;
    logic [31:0]                held_hdr;
    logic [31:0]                pend_id;
    logic [sncr_pkg::LIT_W-1:0] pend_lits;
    logic [31:0]                tbl_id   [sncr_pkg::TYPE_TABLE_DEPTH];
    logic [sncr_pkg::LIT_W-1:0] tbl_lits [sncr_pkg::TYPE_TABLE_DEPTH];
    int                         tbl_count;
    bit                         passing;
    bit                         overflow;

    // Expected output beats, oldest first.
    t_out_beat rewritten_q[$];

    // Words of the module under construction.
    logic [31:0] mod_q[$];

    int  mismatches;
    int  words_sent;
    int  modules_sent;
    int  beats_checked;
    int  rewrites;
    int  malformed_modules;
    int  full_modules;
    int  cycle_count;
    bit  steady_flow;
    t_out_beat got_beat;

    task automatic clear_rewrite_state();
        hdr_seen   = '0;
        words_left = '0;
        kind       = sncr_pkg::KIND_OTHER;
        word_idx   = '0;
        held_hdr   = '0;
        pend_id    = '0;
        pend_lits  = '0;
        tbl_count  = 0;
        passing    = 1'b0;
        overflow   = 1'b0;
    endtask

    // Only entries below the count are live.
    function automatic int lookup_type(input logic [31:0] id);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Record an integer type: literal words are ceil(width/32), saturated.
    task automatic learn_int_type(input logic [31:0] id, input logic [31:0] width);
        logic [63:0] lits;
        int          slot;
        lits = (64'(width) + 64'd31) / 64'd32;
        if (lits > 64'(sncr_pkg::MAX_LITERAL_WORDS)) lits = 64'(sncr_pkg::MAX_LITERAL_WORDS);
        slot = lookup_type(id);
        if (slot >= 0) begin
            tbl_lits[slot] = lits[sncr_pkg::LIT_W-1:0];
        end else if (tbl_count < sncr_pkg::TYPE_TABLE_DEPTH) begin
            tbl_id[tbl_count]   = id;
            tbl_lits[tbl_count] = lits[sncr_pkg::LIT_W-1:0];
            tbl_count++;
        end else begin
            overflow = 1'b1;
        end
    endtask

    // Work out the output beats that one accepted input word causes.
    task automatic predict_word(input logic [31:0] w, input logic last);
        logic [31:0] emit[$];
        logic [15:0] wc;
        logic [15:0] op;
        logic [15:0] idx;
        int          slot;
        bit          cut;
        t_out_beat   beat;
        if (passing) begin
            emit.insert(emit.size(), w);
        end else if (hdr_seen < sncr_pkg::HEADER_WORDS) begin
            emit.insert(emit.size(), w);
            hdr_seen++;
        end else if (words_left == 0) begin
            // First word of an instruction.
            wc = w[31:16];
            op = w[15:0];
            if (wc == 0 || (last && wc > 1)) begin
                passing = 1'b1;
                emit.insert(emit.size(), w);
            end else begin
                words_left = wc - 16'd1;
                word_idx   = 16'd1;
                if (op == sncr_pkg::OP_CONSTANT_NULL && wc == 3) begin
                    kind     = sncr_pkg::KIND_NULL_HELD;
                    held_hdr = w;
                end else begin
                    kind = (op == sncr_pkg::OP_TYPE_INT && wc == 4) ? sncr_pkg::KIND_INT_TYPE
                                                                    : sncr_pkg::KIND_OTHER;
                    emit.insert(emit.size(), w);
                end
            end
        end else begin
            idx = word_idx;
            words_left--;
            word_idx++;
            cut = last && words_left != 0;
            case (kind)
                sncr_pkg::KIND_INT_TYPE: begin
                    if (idx == 1) pend_id = w;
                    else if (idx == 2) learn_int_type(pend_id, w);
                    emit.insert(emit.size(), w);
                end
                sncr_pkg::KIND_NULL_HELD: begin
                    // Type-id word decides: widen to a constant or release as is.
                    slot = cut ? -1 : lookup_type(w);
                    if (slot >= 0) begin
                        pend_lits = tbl_lits[slot];
                        emit.insert(emit.size(), {16'(3 + pend_lits), sncr_pkg::OP_CONSTANT});
                        kind = sncr_pkg::KIND_NULL_REWRITE;
                        rewrites++;
                    end else begin
                        emit.insert(emit.size(), held_hdr);
                        kind = sncr_pkg::KIND_OTHER;
                    end
                    emit.insert(emit.size(), w);
                end
                sncr_pkg::KIND_NULL_REWRITE: begin
                    emit.insert(emit.size(), w);
                    repeat (pend_lits) emit.insert(emit.size(), 32'd0);
                end
                default: emit.insert(emit.size(), w);
            endcase
            if (cut) passing = 1'b1;
            if (words_left == 0) kind = sncr_pkg::KIND_OTHER;
        end

        foreach (emit[i]) begin
            beat.word       = emit[i];
            beat.last       = last && (i == emit.size() - 1);
            beat.malformed  = passing;
            beat.table_full = overflow;
            rewritten_q.insert(rewritten_q.size(), beat);
        end

        if (last) begin
            if (passing) malformed_modules++;
            if (overflow) full_modules++;
            clear_rewrite_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Random helpers.
    // ------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(1, 32);
            2:       return 32'd33;
            3:       return 32'd64;
            4:       return $urandom_range(65, 128);
            5:       return 32'd128;
            6:       return $urandom_range(129, 300);
            7:       return 32'hFFFF_FFFF;
            8:       return 32'hFFFF_FFE1 + $urandom_range(0, 30);
            default: return $urandom;
        endcase
    endfunction

    // Append one word to the module under construction.
    task automatic add_word(input logic [31:0] w);
        mod_q.insert(mod_q.size(), w);
    endtask

    task automatic push_header();
        repeat (5) add_word(rand_word());
    endtask

    task automatic push_type_int(input logic [31:0] id, input logic [31:0] width);
        add_word({16'd4, sncr_pkg::OP_TYPE_INT});
        add_word(id);
        add_word(width);
        add_word($urandom_range(0, 1));
    endtask

    task automatic push_null(input logic [31:0] type_id, input logic [31:0] result_id);
        add_word({16'd3, sncr_pkg::OP_CONSTANT_NULL});
        add_word(type_id);
        add_word(result_id);
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat per call, valid held until taken.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        predict_word(w, last);
    endtask

    task automatic send_module();
        foreach (mod_q[i]) send_word(mod_q[i], i == mod_q.size() - 1);
        modules_sent++;
        mod_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, and a checker for every accepted beat.
    // ------------------------------------------------------------------
    initial begin : out_stall
        int hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_checked++;
            if (rewritten_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: beat with nothing expected, expected none, got word %h last %b",
                         $time, o_out_word, o_out_last);
            end else begin
                got_beat = rewritten_q.pop_front();
                check_field("out_word", got_beat.word, o_out_word);
                check_field("out_last", 32'(got_beat.last), 32'(o_out_last));
                check_field("malformed", 32'(got_beat.malformed), 32'(o_malformed));
                check_field("table_full", 32'(got_beat.table_full), 32'(o_table_full));
            end
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycle_count, rewritten_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Module that ends inside the header: everything passes, no flag.
    task automatic test_short_module();
        add_word(32'h0723_0203);
        add_word('1);
        add_word('0);
        send_module();
    endtask

    // Widen null constants of known widths, redefine one type to width 0,
    // and leave a null constant of an undeclared type alone.
    task automatic test_widen_null();
        steady_flow = 1'b1;
        add_word(32'h0723_0203);
        add_word('0);
        add_word('1);
        add_word(32'd7);
        add_word('0);
        push_type_int(32'd8, 32'd65);
        push_type_int('1, 32'hFFFF_FFFF);
        push_null('1, 32'd20);
        push_type_int(32'd8, 32'd0);
        push_null(32'd8, 32'd21);
        push_null(32'd3, '1);
        send_module();
        steady_flow = 1'b0;
    endtask

    // A zero word count switches the rest of the module to pass-through.
    task automatic test_zero_count();
        push_header();
        add_word({16'd0, sncr_pkg::OP_TYPE_INT});
        push_null(32'd8, 32'd9);
        send_module();
    endtask

    // Module ends mid-instruction: inside a held null constant, and on the
    // first word of a multi-word instruction.
    task automatic test_truncated();
        push_header();
        push_type_int(32'd5, 32'd32);
        add_word({16'd3, sncr_pkg::OP_CONSTANT_NULL});
        add_word(32'd5);
        send_module();
        push_header();
        add_word({16'd4, sncr_pkg::OP_TYPE_INT});
        send_module();
    endtask

    // Fill the type table, then one more distinct id overflows it.
    task automatic test_table_full();
        logic [31:0] base;
        base = $urandom;
        push_header();
        for (int i = 0; i <= sncr_pkg::TYPE_TABLE_DEPTH; i++) begin
            push_type_int(base + i, pick_width());
        end
        push_null(base + sncr_pkg::TYPE_TABLE_DEPTH, $urandom);
        push_null(base, $urandom);
        send_module();
    endtask

    // Mostly well-formed modules with random content, some broken ones.
    task automatic test_random_modules();
        int start_words;
        int n_insn;
        int wc;
        int cut;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            push_header();
            n_insn = $urandom_range(1, 8);
            repeat (n_insn) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: push_type_int($urandom_range(1, TYPE_ID_POOL), pick_width());
                    3, 4, 5: push_null(($urandom_range(0, 4) == 0) ? rand_word()
                                       : $urandom_range(1, TYPE_ID_POOL), rand_word());
                    6: begin
                        // Null-constant or integer-type opcode with a random count from 1 to 6.
                        wc = $urandom_range(1, 6);
                        add_word({16'(wc), ($urandom_range(0, 1) ? sncr_pkg::OP_CONSTANT_NULL
                                                                 : sncr_pkg::OP_TYPE_INT)});
                        repeat (wc - 1) add_word(rand_word());
                    end
                    default: begin
                        wc = $urandom_range(1, 6);
                        add_word({16'(wc), 16'(rand_word())});
                        repeat (wc - 1) add_word(rand_word());
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0: begin
                    add_word({16'd0, 16'(rand_word())});
                    repeat ($urandom_range(0, 4)) add_word(rand_word());
                end
                1: begin
                    cut = $urandom_range(1, mod_q.size() - 1);
                    mod_q = mod_q[0:cut-1];
                end
                2: begin
                    // Oversized count swallows the rest of the module.
                    add_word({16'($urandom_range(8, 16'hFFFF)), 16'(rand_word())});
                    repeat ($urandom_range(0, 3)) add_word(rand_word());
                end
                default: ;
            endcase
            send_module();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        mismatches        = 0;
        words_sent        = 0;
        modules_sent      = 0;
        beats_checked     = 0;
        rewrites          = 0;
        malformed_modules = 0;
        full_modules      = 0;
        cycle_count       = 0;
        steady_flow       = 1'b0;
        clear_rewrite_state();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_module();
        test_widen_null();
        test_zero_count();
        test_truncated();
        test_table_full();
        test_random_modules();

        // Drop valid, drain the expected beats, then watch a little longer.
        i_in_valid <= 1'b0;
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d words in %0d modules and checked %0d output beats.",
                 words_sent, modules_sent, beats_checked);
        $display("Widened %0d null constants; %0d modules malformed, %0d hit a full type table.",
                 rewrites, malformed_modules, full_modules);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
